/* sv/glob_pattern_matcher_assert.svh */
// Assertion macros shared by the glob matcher RTL.
`ifndef GLOB_PATTERN_MATCHER_ASSERT_SVH
`define GLOB_PATTERN_MATCHER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GPM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("glob matcher assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define GPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("glob matcher assertion failed");

`endif

/* sv/gpm_pkg.sv */
// Shared types and constants of the glob matcher.
`default_nettype none

package gpm_pkg;

   localparam int DEFAULT_DEPTH = 64;

   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_LBR   = 8'h5B;
   localparam logic [7:0] CH_RBR   = 8'h5D;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_BSL   = 8'h5C;

   typedef enum logic [1:0] {
      REQ_CLEAR  = 2'd0,
      REQ_APPEND = 2'd1,
      REQ_KEY    = 2'd2,
      REQ_END    = 2'd3
   } req_code_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_MAIN_EVAL,
      OP_ESC_EVAL,
      OP_P_NEXT,
      OP_CL_INIT,
      OP_CL_CARET,
      OP_CL_DONE,
      OP_CL_RANGE,
      OP_CL_LIT,
      OP_Q_INC,
      OP_CL_ESCLIT,
      OP_KEY_DONE
   } dp_op_type;

   typedef enum logic [2:0] {
      RD_P,
      RD_P1,
      RD_Q,
      RD_Q1,
      RD_Q2
   } rd_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_M_RD,
      ST_M_EVAL,
      ST_M_ESC,
      ST_CL_CARET,
      ST_CL_LOOP,
      ST_CL_B,
      ST_CL_D1,
      ST_CL_D2,
      ST_CL_ESC,
      ST_CL_ESCRD
   } state_type;

   typedef struct packed {
      dp_op_type  op;
      rd_sel_type rd_sel;
      logic       lat_b;
   } cmd_type;

   typedef struct packed {
      logic live_p;
      logic p_end;
      logic p1_ok;
      logic q_end;
      logic q1_ok;
      logic q2_ok;
      logic d_lbr;
      logic d_bsl;
      logic d_rbr;
      logic d_dash;
      logic b_bsl;
      logic key_dead;
   } status_type;

endpackage

`default_nettype wire

/* sv/gpm_ram.sv */
// Generic single write port RAM with one registered read port.
`default_nettype none

module gpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = gpm_pkg::DEFAULT_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/gpm_controller.sv */
// Sequencer that walks pattern positions and class bodies for each key word.
`default_nettype none

module gpm_controller (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [1:0]          req_type,
   input  wire gpm_pkg::status_type status,
   output gpm_pkg::cmd_type         cmd,
   output logic                     busy
);

   gpm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gpm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.op     = gpm_pkg::OP_NONE;
      cmd.rd_sel = gpm_pkg::RD_P;
      cmd.lat_b  = 1'b0;
      busy       = (state_ff != gpm_pkg::ST_IDLE);
      unique case (state_ff)
         gpm_pkg::ST_IDLE: begin
            if (start) begin
               cmd.op = gpm_pkg::OP_ACCEPT;
               if (req_type == gpm_pkg::REQ_KEY && !status.key_dead) begin
                  state_in = gpm_pkg::ST_M_RD;
               end
            end
         end
         gpm_pkg::ST_M_RD: begin
            if (status.p_end) begin
               cmd.op   = gpm_pkg::OP_KEY_DONE;
               state_in = gpm_pkg::ST_IDLE;
            end else begin
               cmd.rd_sel = gpm_pkg::RD_P;
               state_in   = gpm_pkg::ST_M_EVAL;
            end
         end
         gpm_pkg::ST_M_EVAL: begin
            if (status.live_p && status.d_lbr) begin
               if (status.p1_ok) begin
                  cmd.op     = gpm_pkg::OP_CL_INIT;
                  cmd.rd_sel = gpm_pkg::RD_P1;
                  state_in   = gpm_pkg::ST_CL_CARET;
               end else begin
                  cmd.op   = gpm_pkg::OP_P_NEXT;
                  state_in = gpm_pkg::ST_M_RD;
               end
            end else if (status.live_p && status.d_bsl) begin
               if (status.p1_ok) begin
                  cmd.rd_sel = gpm_pkg::RD_P1;
                  state_in   = gpm_pkg::ST_M_ESC;
               end else begin
                  cmd.op   = gpm_pkg::OP_P_NEXT;
                  state_in = gpm_pkg::ST_M_RD;
               end
            end else begin
               cmd.op   = gpm_pkg::OP_MAIN_EVAL;
               state_in = gpm_pkg::ST_M_RD;
            end
         end
         gpm_pkg::ST_M_ESC: begin
            cmd.op   = gpm_pkg::OP_ESC_EVAL;
            state_in = gpm_pkg::ST_M_RD;
         end
         gpm_pkg::ST_CL_CARET: begin
            cmd.op   = gpm_pkg::OP_CL_CARET;
            state_in = gpm_pkg::ST_CL_LOOP;
         end
         gpm_pkg::ST_CL_LOOP: begin
            if (status.q_end) begin
               // Unterminated class: this position dies.
               cmd.op   = gpm_pkg::OP_P_NEXT;
               state_in = gpm_pkg::ST_M_RD;
            end else begin
               cmd.rd_sel = gpm_pkg::RD_Q;
               state_in   = gpm_pkg::ST_CL_B;
            end
         end
         gpm_pkg::ST_CL_B: begin
            cmd.lat_b = 1'b1;
            if (status.d_rbr) begin
               cmd.op   = gpm_pkg::OP_CL_DONE;
               state_in = gpm_pkg::ST_M_RD;
            end else if (status.q2_ok) begin
               cmd.rd_sel = gpm_pkg::RD_Q1;
               state_in   = gpm_pkg::ST_CL_D1;
            end else begin
               state_in = gpm_pkg::ST_CL_ESC;
            end
         end
         gpm_pkg::ST_CL_D1: begin
            if (status.d_dash) begin
               cmd.rd_sel = gpm_pkg::RD_Q2;
               state_in   = gpm_pkg::ST_CL_D2;
            end else begin
               state_in = gpm_pkg::ST_CL_ESC;
            end
         end
         gpm_pkg::ST_CL_D2: begin
            if (!status.d_rbr) begin
               cmd.op   = gpm_pkg::OP_CL_RANGE;
               state_in = gpm_pkg::ST_CL_LOOP;
            end else begin
               state_in = gpm_pkg::ST_CL_ESC;
            end
         end
         gpm_pkg::ST_CL_ESC: begin
            if (status.b_bsl && status.q1_ok) begin
               cmd.op     = gpm_pkg::OP_Q_INC;
               cmd.rd_sel = gpm_pkg::RD_Q1;
               state_in   = gpm_pkg::ST_CL_ESCRD;
            end else begin
               cmd.op   = gpm_pkg::OP_CL_LIT;
               state_in = gpm_pkg::ST_CL_LOOP;
            end
         end
         gpm_pkg::ST_CL_ESCRD: begin
            cmd.op   = gpm_pkg::OP_CL_ESCLIT;
            state_in = gpm_pkg::ST_CL_LOOP;
         end
         default: begin
            state_in = gpm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* sv/gpm_datapath.sv */
// Pattern store, live position sets and class evaluation of the glob matcher.
`default_nettype none

`include "glob_pattern_matcher_assert.svh"

module gpm_datapath #(
   parameter int PATTERN_DEPTH = gpm_pkg::DEFAULT_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [1:0]       req_type,
   input  wire logic [7:0]       req_data_byte,
   input  wire gpm_pkg::cmd_type cmd,
   output gpm_pkg::status_type   status,
   output logic                  rsp_valid,
   output logic                  rsp_matched,
   output logic                  rsp_pattern_overflow
);

   localparam int AW = $clog2(PATTERN_DEPTH);
   localparam int LW = $clog2(PATTERN_DEPTH + 1);
   localparam int NP = PATTERN_DEPTH + 1;

   logic [LW-1:0] len_ff, len_in, lead_ff, lead_in, p_ff, p_in, q_ff, q_in;
   logic          all_star_ff, all_star_in, ovf_ff, ovf_in, dead_ff, dead_in;
   logic [NP-1:0] live_ff, live_in, nxt_ff, nxt_in;
   logic [7:0]    b_ff, b_in, c_ff, c_in;
   logic          neg_ff, neg_in, hit_ff, hit_in;
   logic          rsp_valid_ff, rsp_valid_in, rsp_matched_ff, rsp_matched_in;
   logic          rsp_ovf_ff, rsp_ovf_in;
   logic          restart;
   logic          end_acc;

   logic          wr_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   logic [LW-1:0] p_plus1, p_plus2, q_plus1, q_plus2;
   logic [LW:0]   len_w;
   logic          d_star, d_quest, d_eq_c, np;

   // Live set right after a restart: start position plus the leading stars.
   function automatic logic [NP-1:0] star_mask(input logic [LW-1:0] lead);
      logic [NP-1:0] m;
      for (int i = 0; i < NP; i++) begin
         m[i] = (LW'(i) <= lead);
      end
      return m;
   endfunction

   gpm_ram #(.WIDTH(8), .DEPTH(PATTERN_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_ff[AW-1:0]),
      .wr_data (req_data_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign p_plus1 = p_ff + LW'(1);
   assign p_plus2 = p_ff + LW'(2);
   assign q_plus1 = q_ff + LW'(1);
   assign q_plus2 = q_ff + LW'(2);
   assign len_w   = {1'b0, len_ff};
   assign end_acc = (cmd.op == gpm_pkg::OP_ACCEPT) && (req_type == gpm_pkg::REQ_END);

   always_comb begin
      unique case (cmd.rd_sel)
         gpm_pkg::RD_P:  rd_addr = p_ff[AW-1:0];
         gpm_pkg::RD_P1: rd_addr = p_plus1[AW-1:0];
         gpm_pkg::RD_Q:  rd_addr = q_ff[AW-1:0];
         gpm_pkg::RD_Q1: rd_addr = q_plus1[AW-1:0];
         gpm_pkg::RD_Q2: rd_addr = q_plus2[AW-1:0];
         default:        rd_addr = p_ff[AW-1:0];
      endcase
   end

   assign d_star  = (rd_data == gpm_pkg::CH_STAR);
   assign d_quest = (rd_data == gpm_pkg::CH_QUEST);
   assign d_eq_c  = (rd_data == c_ff);

   always_comb begin
      status.live_p   = live_ff[p_ff];
      status.p_end    = (p_ff == len_ff);
      status.p1_ok    = ({1'b0, p_ff} + (LW + 1)'(1)) < len_w;
      status.q_end    = (q_ff >= len_ff);
      status.q1_ok    = ({1'b0, q_ff} + (LW + 1)'(1)) < len_w;
      status.q2_ok    = ({1'b0, q_ff} + (LW + 1)'(2)) < len_w;
      status.d_lbr    = (rd_data == gpm_pkg::CH_LBR);
      status.d_bsl    = (rd_data == gpm_pkg::CH_BSL);
      status.d_rbr    = (rd_data == gpm_pkg::CH_RBR);
      status.d_dash   = (rd_data == gpm_pkg::CH_DASH);
      status.b_bsl    = (b_ff == gpm_pkg::CH_BSL);
      status.key_dead = dead_ff;
   end

   always_comb begin
      len_in         = len_ff;
      lead_in        = lead_ff;
      all_star_in    = all_star_ff;
      ovf_in         = ovf_ff;
      dead_in        = dead_ff;
      live_in        = live_ff;
      nxt_in         = nxt_ff;
      p_in           = p_ff;
      q_in           = q_ff;
      b_in           = b_ff;
      c_in           = c_ff;
      neg_in         = neg_ff;
      hit_in         = hit_ff;
      rsp_valid_in   = 1'b0;
      rsp_matched_in = rsp_matched_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      wr_en          = 1'b0;
      restart        = 1'b0;
      np             = nxt_ff[p_ff] | (live_ff[p_ff] & d_star);
      unique case (cmd.op)
         gpm_pkg::OP_NONE: begin
         end
         gpm_pkg::OP_ACCEPT: begin
            unique case (req_type)
               gpm_pkg::REQ_CLEAR: begin
                  len_in      = '0;
                  ovf_in      = 1'b0;
                  lead_in     = '0;
                  all_star_in = 1'b1;
                  restart     = 1'b1;
               end
               gpm_pkg::REQ_APPEND: begin
                  if (len_ff < LW'(PATTERN_DEPTH)) begin
                     wr_en  = 1'b1;
                     len_in = len_ff + LW'(1);
                     if (all_star_ff && req_data_byte == gpm_pkg::CH_STAR) begin
                        lead_in = lead_ff + LW'(1);
                     end else begin
                        all_star_in = 1'b0;
                     end
                  end else begin
                     ovf_in = 1'b1;
                  end
                  restart = 1'b1;
               end
               gpm_pkg::REQ_KEY: begin
                  p_in   = '0;
                  nxt_in = '0;
                  c_in   = req_data_byte;
               end
               gpm_pkg::REQ_END: begin
                  rsp_valid_in   = 1'b1;
                  rsp_matched_in = !ovf_ff && !dead_ff && live_ff[len_ff];
                  rsp_ovf_in     = ovf_ff;
                  restart        = 1'b1;
               end
               default: begin
               end
            endcase
         end
         gpm_pkg::OP_MAIN_EVAL: begin
            // A star keeps its own position and, being live, opens the next.
            if (d_star) begin
               nxt_in[p_ff] = np;
               if (np) begin
                  nxt_in[p_plus1] = 1'b1;
               end
            end else if (live_ff[p_ff] && (d_quest || d_eq_c)) begin
               nxt_in[p_plus1] = 1'b1;
            end
            p_in = p_plus1;
         end
         gpm_pkg::OP_ESC_EVAL: begin
            if (d_eq_c) begin
               nxt_in[p_plus2] = 1'b1;
            end
            p_in = p_plus1;
         end
         gpm_pkg::OP_P_NEXT: begin
            p_in = p_plus1;
         end
         gpm_pkg::OP_CL_INIT: begin
            q_in   = p_plus1;
            neg_in = 1'b0;
            hit_in = 1'b0;
         end
         gpm_pkg::OP_CL_CARET: begin
            if (rd_data == gpm_pkg::CH_CARET) begin
               neg_in = 1'b1;
               q_in   = q_plus1;
            end
         end
         gpm_pkg::OP_CL_DONE: begin
            if (neg_ff != hit_ff) begin
               nxt_in[q_plus1] = 1'b1;
            end
            p_in = p_plus1;
         end
         gpm_pkg::OP_CL_RANGE: begin
            if (b_ff <= c_ff && c_ff <= rd_data) begin
               hit_in = 1'b1;
            end
            q_in = q_ff + LW'(3);
         end
         gpm_pkg::OP_CL_LIT: begin
            if (b_ff == c_ff) begin
               hit_in = 1'b1;
            end
            q_in = q_plus1;
         end
         gpm_pkg::OP_Q_INC: begin
            q_in = q_plus1;
         end
         gpm_pkg::OP_CL_ESCLIT: begin
            if (d_eq_c) begin
               hit_in = 1'b1;
            end
            q_in = q_plus1;
         end
         gpm_pkg::OP_KEY_DONE: begin
            live_in = nxt_ff;
            dead_in = ~|nxt_ff;
         end
         default: begin
         end
      endcase
      if (restart) begin
         live_in = star_mask(lead_in);
         dead_in = 1'b0;
      end
      if (cmd.lat_b) begin
         b_in = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         lead_ff      <= '0;
         all_star_ff  <= 1'b1;
         ovf_ff       <= 1'b0;
         dead_ff      <= 1'b0;
         live_ff      <= NP'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         lead_ff      <= lead_in;
         all_star_ff  <= all_star_in;
         ovf_ff       <= ovf_in;
         dead_ff      <= dead_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nxt_ff         <= nxt_in;
      p_ff           <= p_in;
      q_ff           <= q_in;
      b_ff           <= b_in;
      c_ff           <= c_in;
      neg_ff         <= neg_in;
      hit_ff         <= hit_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = rsp_matched_ff;
   assign rsp_pattern_overflow = rsp_ovf_ff;

   `GPM_ASSERT_IMP(a_ovf_only_full, clock, reset, ovf_ff, len_ff == LW'(PATTERN_DEPTH))
   `GPM_ASSERT_IMP(a_dead_empty, clock, reset, dead_ff, live_ff == '0)
   `GPM_ASSERT_NEXT(a_end_gives_rsp, clock, reset, end_acc, rsp_valid_ff)
   `GPM_ASSERT_IMP(a_rsp_from_end, clock, reset, rsp_valid_ff, $past(end_acc))

endmodule

`default_nettype wire

/* sv/glob_pattern_matcher.sv */
// Top level of the glob matcher: sequencer plus pattern datapath.
// Clear, append and end-of-key words are taken while idle and may follow back to back; the
// end-of-key result is on the rsp_ ports the cycle after it is taken, and cannot be stalled.
// A key word visits each stored position, reading on for a live escape or a live class body;
// one that arrives with no position live is taken without leaving idle.
// Synchronous reset empties the pattern and makes only the start position live.
`default_nettype none

module glob_pattern_matcher #(
   parameter int PATTERN_DEPTH = gpm_pkg::DEFAULT_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic [1:0] req_type,
   input  wire logic [7:0] req_data_byte,
   output logic            busy,
   output logic            rsp_valid,
   output logic            rsp_matched,
   output logic            rsp_pattern_overflow
);

   // The controller steps through positions; the datapath owns all pattern state.
   gpm_pkg::cmd_type    cmd;
   gpm_pkg::status_type status;

   gpm_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // The live set is kept as an NFA; a key word is one forward sweep over the store.
   gpm_datapath #(.PATTERN_DEPTH(PATTERN_DEPTH)) u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_type             (req_type),
      .req_data_byte        (req_data_byte),
      .cmd                  (cmd),
      .status               (status),
      .rsp_valid            (rsp_valid),
      .rsp_matched          (rsp_matched),
      .rsp_pattern_overflow (rsp_pattern_overflow)
   );

endmodule

`default_nettype wire
